[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the Playfair decrypt core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is held.
`define PDD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pdd port check failed");

// Check that also holds across reset.
`define PDD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pdd port check failed");

`endif

[hdl/pdd_pkg.sv]
// ---------------------------------------------------------------------------
// pdd_pkg
// Types, constants and helpers shared by the Playfair decrypt core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdd_pkg;

    localparam int Side     = 5;
    localparam int Cells    = Side * Side;
    localparam int Alphabet = 26;

    localparam logic [4:0] LetterI    = 5'd8;
    localparam logic [4:0] LetterJ    = 5'd9;
    localparam logic [4:0] LastLetter = 5'(Alphabet - 1);
    localparam logic [4:0] CellCount  = 5'(Cells);

    typedef logic [4:0] letter_t;
    typedef logic [Cells-1:0][4:0] grid_t;
    typedef logic [Cells-1:0] hit_vec_t;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_KEY      = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_DECRYPT  = 2'd3
    } opcode_t;

    // Table maintenance request from the top level.
    typedef struct packed {
        logic    valid;
        opcode_t opcode;
        letter_t letter;
    } table_cmd_t;

    // Table status towards the top level.
    typedef struct packed {
        logic ready;
        logic busy;
    } table_status_t;

    // The square has no j: a ciphertext j is looked up as i.
    function automatic letter_t map_j(input letter_t x);
        return (x == LetterJ) ? LetterI : x;
    endfunction

    // One step back around a row or a column.
    function automatic logic [2:0] wrap_dec(input logic [2:0] x);
        return (x == 3'd0) ? 3'(Side - 1) : x - 3'd1;
    endfunction

endpackage

[hdl/playfair_digraph_decrypt_core.sv]
// ---------------------------------------------------------------------------
// playfair_digraph_decrypt_core
// Playfair digraph decryption with a key square built on chip.
// ---------------------------------------------------------------------------
// Usage: requests arrive on the s_ stream. s_tuser carries the opcode (clear,
// key letter, complete, decrypt) and s_tdata the two letters, coded a=0..z=25.
// Only decrypt requests produce a result on the m_ stream: the two plaintext
// letters in m_tdata and the table error flag in m_tuser, which is set (with
// zero letters) when the square was not yet completed.
// Pipeline: an accepted decrypt request is registered in the lane compare
// stage, then in the output register. Throughput: one request per cycle for
// clear, key and decrypt while no sweep runs and the receiver does not stall.
// A complete request runs the fill sweep over the alphabet, one letter a
// cycle, and holds s_tready low while it runs; that sweep is the other stall.
// Reset (aresetn low, synchronous) empties the square's bookkeeping and
// drops any result in flight. When the receiver stalls, the result is held
// in the output register and one further decrypt may wait in the compare
// stage; after that s_tready falls until the receiver takes the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module playfair_digraph_decrypt_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] letter_first, [9:5] letter_second
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] plain_first, [9:5] plain_second
    output logic        m_tuser    // [0] table_error
);

    pdd_pkg::table_cmd_t    tcmd;
    pdd_pkg::table_status_t tstat;
    pdd_pkg::grid_t         grid;
    pdd_pkg::opcode_t       opcode;
    pdd_pkg::letter_t       letter_a, letter_b;
    pdd_pkg::hit_vec_t      hit_a, hit_b;
    pdd_pkg::letter_t       plain_a, plain_b;

    logic                   accept, accept_dec, advance;

    // Compare stage: holds one decrypt request as lane hit vectors.
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_err_reg;
    pdd_pkg::hit_vec_t      s1_hit_a_reg, s1_hit_b_reg;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    pdd_pkg::letter_t       m_first_reg, m_second_reg;
    logic                   m_err_reg;

    assign opcode   = pdd_pkg::opcode_t'(s_tuser);
    assign letter_a = pdd_pkg::map_j(s_tdata[4:0]);
    assign letter_b = pdd_pkg::map_j(s_tdata[9:5]);

    // The output register frees up when it is empty or being read.
    assign advance    = !m_valid_reg || m_tready;
    assign s_tready   = !tstat.busy && (!s1_valid_reg || advance);
    assign accept     = s_tvalid && s_tready;
    assign accept_dec = accept && (opcode == pdd_pkg::OP_DECRYPT);

    // Table writes land at or after the edge on which a pending decrypt
    // leaves the compare stage, so both stages see the same square.
    assign tcmd.valid  = accept && (opcode != pdd_pkg::OP_DECRYPT);
    assign tcmd.opcode = opcode;
    assign tcmd.letter = s_tdata[4:0];

    pdd_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tcmd),
        .grid    (grid),
        .status  (tstat)
    );

    for (genvar k = 0; k < pdd_pkg::Cells; k++) begin : g_lane
        pdd_lane u_lane (
            .cell_letter (grid[k]),
            .letter_a    (letter_a),
            .letter_b    (letter_b),
            .hit_a       (hit_a[k]),
            .hit_b       (hit_b[k])
        );
    end

    pdd_merge u_merge (
        .hit_a   (s1_hit_a_reg),
        .hit_b   (s1_hit_b_reg),
        .grid    (grid),
        .plain_a (plain_a),
        .plain_b (plain_b)
    );

    always_comb begin
        if (accept_dec) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance) begin
            m_valid_next = s1_valid_reg;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_dec) begin
            s1_err_reg   <= !tstat.ready;
            s1_hit_a_reg <= hit_a;
            s1_hit_b_reg <= hit_b;
        end
        if (advance && s1_valid_reg) begin
            m_err_reg    <= s1_err_reg;
            m_first_reg  <= s1_err_reg ? 5'd0 : plain_a;
            m_second_reg <= s1_err_reg ? 5'd0 : plain_b;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_second_reg, m_first_reg};
    assign m_tuser  = m_err_reg;

endmodule

[hdl/pdd_table.sv]
// ---------------------------------------------------------------------------
// pdd_table
// Key square storage: key letter placement and the completion sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdd_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pdd_pkg::table_cmd_t   cmd,
    output pdd_pkg::grid_t        grid,
    output pdd_pkg::table_status_t status
);

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    state_t                 state_reg, state_next;
    pdd_pkg::grid_t         grid_reg;
    logic [25:0]            used_reg, used_next;
    logic [4:0]             fill_reg, fill_next;
    logic                   ready_reg, ready_next;
    pdd_pkg::letter_t       sweep_reg, sweep_next;

    pdd_pkg::letter_t       place_letter;
    logic                   place_en;
    logic                   place_ok;

    // One letter is placed per cycle, either from a key request or from the sweep.
    always_comb begin
        place_letter = (state_reg == ST_FILL) ? sweep_reg : cmd.letter;
        place_en     = (state_reg == ST_FILL) ||
                       (cmd.valid && cmd.opcode == pdd_pkg::OP_KEY && !ready_reg);
        place_ok     = place_en && (place_letter <= pdd_pkg::LastLetter) &&
                       (place_letter != pdd_pkg::LetterJ) &&
                       !used_reg[place_letter] && (fill_reg < pdd_pkg::CellCount);
    end

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        fill_next  = fill_reg;
        ready_next = ready_reg;
        sweep_next = sweep_reg;
        if (place_ok) begin
            used_next[place_letter] = 1'b1;
            fill_next               = fill_reg + 5'd1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.valid && cmd.opcode == pdd_pkg::OP_CLEAR) begin
                    used_next  = '0;
                    fill_next  = '0;
                    ready_next = 1'b0;
                end else if (cmd.valid && cmd.opcode == pdd_pkg::OP_COMPLETE &&
                             !ready_reg) begin
                    state_next = ST_FILL;
                    sweep_next = '0;
                end
            end
            ST_FILL: begin
                if (sweep_reg == pdd_pkg::LastLetter) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end else begin
                    sweep_next = sweep_reg + 5'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            fill_reg  <= '0;
            ready_reg <= 1'b0;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            ready_reg <= ready_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (place_ok) begin
            grid_reg[fill_reg] <= place_letter;
        end
    end

    assign grid          = grid_reg;
    assign status.ready  = ready_reg;
    assign status.busy   = (state_reg == ST_FILL);

endmodule

[hdl/pdd_lane.sv]
// ---------------------------------------------------------------------------
// pdd_lane
// One cell of the key square compared against both ciphertext letters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdd_lane (
    input  pdd_pkg::letter_t cell_letter,
    input  pdd_pkg::letter_t letter_a,
    input  pdd_pkg::letter_t letter_b,
    output logic             hit_a,
    output logic             hit_b
);

    assign hit_a = (cell_letter == letter_a);
    assign hit_b = (cell_letter == letter_b);

endmodule

[hdl/pdd_merge.sv]
// ---------------------------------------------------------------------------
// pdd_merge
// Combines the lane hits into positions and picks the two plaintext letters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdd_merge (
    input  pdd_pkg::hit_vec_t hit_a,
    input  pdd_pkg::hit_vec_t hit_b,
    input  pdd_pkg::grid_t    grid,
    output pdd_pkg::letter_t  plain_a,
    output pdd_pkg::letter_t  plain_b
);

    logic [pdd_pkg::Cells-1:0][2:0] row_a_t, col_a_t, row_b_t, col_b_t;
    logic [2:0] r1, c1, r2, c2;
    logic [2:0] nr1, nc1, nr2, nc2;
    logic [4:0] t1, t2;

    // Letters in a complete square are unique, so an OR of the hit terms
    // gives the position; no hit leaves row 0, column 0.
    for (genvar k = 0; k < pdd_pkg::Cells; k++) begin : g_pos
        localparam logic [2:0] Row = 3'(k / pdd_pkg::Side);
        localparam logic [2:0] Col = 3'(k % pdd_pkg::Side);
        assign row_a_t[k] = hit_a[k] ? Row : 3'd0;
        assign col_a_t[k] = hit_a[k] ? Col : 3'd0;
        assign row_b_t[k] = hit_b[k] ? Row : 3'd0;
        assign col_b_t[k] = hit_b[k] ? Col : 3'd0;
    end

    always_comb begin
        r1 = '0;
        c1 = '0;
        r2 = '0;
        c2 = '0;
        for (int k = 0; k < pdd_pkg::Cells; k++) begin
            r1 = r1 | row_a_t[k];
            c1 = c1 | col_a_t[k];
            r2 = r2 | row_b_t[k];
            c2 = c2 | col_b_t[k];
        end
    end

    // Same column: move up. Same row: move left. Otherwise swap columns.
    always_comb begin
        priority if (c1 == c2) begin
            nr1 = pdd_pkg::wrap_dec(r1);
            nc1 = c1;
            nr2 = pdd_pkg::wrap_dec(r2);
            nc2 = c2;
        end else if (r1 == r2) begin
            nr1 = r1;
            nc1 = pdd_pkg::wrap_dec(c1);
            nr2 = r2;
            nc2 = pdd_pkg::wrap_dec(c2);
        end else begin
            nr1 = r1;
            nc1 = c2;
            nr2 = r2;
            nc2 = c1;
        end
        t1 = 5'(nr1) * 5'(pdd_pkg::Side) + 5'(nc1);
        t2 = 5'(nr2) * 5'(pdd_pkg::Side) + 5'(nc2);
    end

    always_comb begin
        plain_a = '0;
        plain_b = '0;
        for (int k = 0; k < pdd_pkg::Cells; k++) begin
            if (t1 == 5'(k)) begin
                plain_a = plain_a | grid[k];
            end
            if (t2 == 5'(k)) begin
                plain_b = plain_b | grid[k];
            end
        end
    end

endmodule

[hdl/pdd_checker.sv]
// ---------------------------------------------------------------------------
// pdd_checker
// Port-level checks on the result stream of the Playfair decrypt core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    logic        stalled;
    logic        letters_legal;
    logic [16:0] result_word;

    assign stalled       = m_tvalid && !m_tready;
    assign result_word   = {m_tuser, m_tdata};
    assign letters_legal = (m_tdata[4:0] <= pdd_pkg::LastLetter) &&
                           (m_tdata[9:5] <= pdd_pkg::LastLetter) &&
                           (m_tdata[15:10] == 6'd0);

    `PDD_ASSERT(a_result_held, aclk, aresetn, stalled |=> m_tvalid && $stable(result_word))
    `PDD_ASSERT(a_error_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == 16'd0)
    `PDD_ASSERT(a_letters_legal, aclk, aresetn, m_tvalid && !m_tuser |-> letters_legal)
    `PDD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind playfair_digraph_decrypt_core pdd_checker u_pdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
